// File: hw/rtl/bhre_pkg.sv
// shared types and constants for the button hold/repeat event unit
`default_nettype none

package bhre_pkg;

	// timestamp width, elapsed time wraps modulo 2^TIME_W
	localparam int TIME_W = 32;

	// configuration port widths
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 32;

	// configuration register indexes
	typedef enum logic [CFG_IDX_W-1:0] {
		REG_HOLD_TIME     = 3'd0,
		REG_HOLD_ENABLE   = 3'd1,
		REG_REPEAT_TIME   = 3'd2,
		REG_REPEAT_ENABLE = 3'd3,
		REG_INITIAL_LEVEL = 3'd4,
		REG_EVENTS_ENABLE = 3'd5
	} cfg_reg_t;

	// event codes carried in event_res
	typedef enum logic [1:0] {
		EV_NONE    = 2'd0,
		EV_PRESS   = 2'd1,
		EV_RELEASE = 2'd2,
		EV_HOLD    = 2'd3
	} event_t;

	// input transaction payload
	typedef struct packed {
		logic [TIME_W-1:0] now;
		logic              level_in;
	} in_t;

	// output transaction payload
	typedef struct packed {
		logic [1:0] event_res;
		logic       level;
		logic       last;
	} res_t;

	// configuration register file contents
	typedef struct packed {
		logic [TIME_W-1:0] hold_ticks;
		logic              hold_enable;
		logic [TIME_W-1:0] repeat_ticks;
		logic              repeat_enable;
		logic              initial_level;
		logic              events_enable;
	} cfg_t;

	// level reload request raised by a write of initial_level
	typedef struct packed {
		logic load;
		logic value;
	} lvl_wr_t;

	// results of one sample handed from the core to the output buffer
	typedef struct packed {
		res_t first;
		res_t second;
		logic two;
	} res_pair_t;

endpackage

`default_nettype wire

// File: hw/rtl/bhre_cfg.sv
// configuration register file of the button hold/repeat event unit
`default_nettype none

module bhre_cfg (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            cfg_we,
	input  wire logic [bhre_pkg::CFG_IDX_W-1:0]  cfg_idx,
	input  wire logic [bhre_pkg::CFG_DATA_W-1:0] cfg_wdata,
	output bhre_pkg::cfg_t                       cfg,
	output bhre_pkg::lvl_wr_t                    lvl_wr
);

	bhre_pkg::cfg_t cfg_q;

	// register writes, unknown indexes are dropped
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.hold_ticks    <= '0;
			cfg_q.hold_enable   <= 1'b0;
			cfg_q.repeat_ticks  <= '0;
			cfg_q.repeat_enable <= 1'b0;
			cfg_q.initial_level <= 1'b0;
			cfg_q.events_enable <= 1'b1;
		end else if (cfg_we) begin
			case (cfg_idx)
				bhre_pkg::REG_HOLD_TIME:     cfg_q.hold_ticks    <= cfg_wdata[bhre_pkg::TIME_W-1:0];
				bhre_pkg::REG_HOLD_ENABLE:   cfg_q.hold_enable   <= cfg_wdata[0];
				bhre_pkg::REG_REPEAT_TIME:   cfg_q.repeat_ticks  <= cfg_wdata[bhre_pkg::TIME_W-1:0];
				bhre_pkg::REG_REPEAT_ENABLE: cfg_q.repeat_enable <= cfg_wdata[0];
				bhre_pkg::REG_INITIAL_LEVEL: cfg_q.initial_level <= cfg_wdata[0];
				bhre_pkg::REG_EVENTS_ENABLE: cfg_q.events_enable <= cfg_wdata[0];
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

	// a write of initial_level also reloads the stored level
	assign lvl_wr = {cfg_we && (cfg_idx == bhre_pkg::REG_INITIAL_LEVEL), cfg_wdata[0]};

endmodule

`default_nettype wire

// File: hw/rtl/bhre_core.sv
// edge detection, hold timer and event selection for one sample
`default_nettype none

module bhre_core (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire bhre_pkg::cfg_t      cfg,
	input  wire bhre_pkg::lvl_wr_t   lvl_wr,
	input  wire logic                commit,
	input  wire bhre_pkg::in_t       smp,
	output bhre_pkg::res_pair_t      pair
);

	typedef enum logic [1:0] {
		MODE_IDLE   = 2'd0,
		MODE_HOLD   = 2'd1,
		MODE_REPEAT = 2'd2
	} mode_t;

	logic                        level_q;
	mode_t                       mode_q;
	logic [bhre_pkg::TIME_W-1:0] mark_q;

	logic                        edge_seen;
	mode_t                       mode_e;
	logic [bhre_pkg::TIME_W-1:0] mark_e;
	logic [bhre_pkg::TIME_W-1:0] elapsed;
	logic                        fire;
	mode_t                       mode_n;
	logic [bhre_pkg::TIME_W-1:0] mark_n;
	logic [1:0]                  ev_edge;
	logic                        show;

	// level edge: press may start hold timing, release stops it
	always_comb begin
		edge_seen = (smp.level_in != level_q);
		mode_e    = mode_q;
		mark_e    = mark_q;
		if (edge_seen) begin
			if (smp.level_in) begin
				if (cfg.hold_enable) begin
					mode_e = MODE_HOLD;
					mark_e = smp.now;
				end
			end else begin
				mode_e = MODE_IDLE;
			end
		end
	end

	// elapsed time against the threshold of the current timer mode
	always_comb begin
		elapsed = smp.now - mark_e;
		fire    = ((mode_e == MODE_HOLD) && (elapsed >= cfg.hold_ticks)) ||
		          ((mode_e == MODE_REPEAT) && (elapsed >= cfg.repeat_ticks));
		mode_n  = mode_e;
		mark_n  = mark_e;
		if (fire) begin
			if (cfg.repeat_enable) begin
				mode_n = MODE_REPEAT;
				mark_n = smp.now;
			end else begin
				mode_n = MODE_IDLE;
			end
		end
	end

	// event list for this sample, a single none result when empty or muted
	always_comb begin
		ev_edge = smp.level_in ? bhre_pkg::EV_PRESS : bhre_pkg::EV_RELEASE;
		show    = cfg.events_enable && (edge_seen || fire);

		pair.first.level  = smp.level_in;
		pair.second.level = smp.level_in;
		pair.second.event_res = bhre_pkg::EV_HOLD;
		pair.second.last      = 1'b1;
		pair.two              = show && edge_seen && fire;

		if (!show) begin
			pair.first.event_res = bhre_pkg::EV_NONE;
		end else if (edge_seen) begin
			pair.first.event_res = ev_edge;
		end else begin
			pair.first.event_res = bhre_pkg::EV_HOLD;
		end
		pair.first.last = !pair.two;
	end

	// state update when the sample moves into the output buffer; a reload of initial_level takes priority
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			level_q <= 1'b0;
			mode_q  <= MODE_IDLE;
			mark_q  <= '0;
		end else if (lvl_wr.load) begin
			level_q <= lvl_wr.value;
		end else if (commit) begin
			level_q <= smp.level_in;
			mode_q  <= mode_n;
			mark_q  <= mark_n;
		end
	end

endmodule

`default_nettype wire

// File: hw/rtl/bhre_out.sv
// two-entry result buffer that sends one result per output transaction
`default_nettype none

module bhre_out (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 load,
	input  wire bhre_pkg::res_pair_t  pair,
	output logic                      take,
	output logic                      out_valid,
	input  wire logic                 out_stall,
	output bhre_pkg::res_t            out_data
);

	bhre_pkg::res_t r0_q;
	bhre_pkg::res_t r1_q;
	logic [1:0]     cnt_q;
	logic           out_acc;

	assign out_acc   = out_valid && !out_stall;
	assign out_valid = (cnt_q != 2'd0);
	assign out_data  = r0_q;

	// room for a new sample once the buffer is empty or its last result leaves
	assign take = (cnt_q == 2'd0) || ((cnt_q == 2'd1) && !out_stall);

	// fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= 2'd0;
		end else if (load) begin
			cnt_q <= pair.two ? 2'd2 : 2'd1;
		end else if (out_acc) begin
			cnt_q <= cnt_q - 2'd1;
		end
	end

	// result slots, the second moves up after the first is taken
	always_ff @(posedge clk) begin
		if (load) begin
			r0_q <= pair.first;
			r1_q <= pair.second;
		end else if (out_acc) begin
			r0_q <= r1_q;
		end
	end

	a_cnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q != 2'd3)
		else $error("result buffer count out of range");

	a_single_last: assert property (@(posedge clk) disable iff (!arst_n)
		(cnt_q == 2'd1) |-> r0_q.last)
		else $error("only result of a sample not marked last");

	a_pair_last: assert property (@(posedge clk) disable iff (!arst_n)
		(cnt_q == 2'd2) |-> (!r0_q.last && r1_q.last))
		else $error("pending result pair marked wrongly");

	a_load_empty: assert property (@(posedge clk) disable iff (!arst_n)
		load |=> (cnt_q == 2'd1 || cnt_q == 2'd2))
		else $error("loaded sample left no result");

endmodule

`default_nettype wire

// File: hw/rtl/button_hold_repeat_events_unit.sv
// top level of the button press, hold and auto-repeat event unit
// path: a sample is held in the input register, then its results in the result buffer that drives the output
// throughput: one sample per cycle while the output does not stall; a sample with a press and a hold event in one go
//   sends two result transactions and stalls the input until the second leaves, set by the result buffer
// reset: arst_n clears the control state asynchronously, the input and result data registers are not reset;
//   stored level 0, timer idle, all registers 0 except events_enable which comes up as 1
`default_nettype none

module button_hold_repeat_events_unit (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            in_valid,
	output logic                                 in_stall,
	input  wire bhre_pkg::in_t                   in_data,
	output logic                                 out_valid,
	input  wire logic                            out_stall,
	output bhre_pkg::res_t                       out_data,
	input  wire logic                            cfg_we,
	input  wire logic [bhre_pkg::CFG_IDX_W-1:0]  cfg_idx,
	input  wire logic [bhre_pkg::CFG_DATA_W-1:0] cfg_wdata
);

	bhre_pkg::cfg_t      cfg;
	bhre_pkg::lvl_wr_t   lvl_wr;
	bhre_pkg::res_pair_t pair;
	bhre_pkg::in_t       in_s1;
	logic                in_v_s1;
	logic                take;
	logic                advance;
	logic                in_acc;

	assign advance  = in_v_s1 && take;
	assign in_stall = in_v_s1 && !take;
	assign in_acc   = in_valid && !in_stall;

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_v_s1 <= 1'b0;
		end else if (in_acc) begin
			in_v_s1 <= 1'b1;
		end else if (advance) begin
			in_v_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			in_s1 <= in_data;
		end
	end

	bhre_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_idx   (cfg_idx),
		.cfg_wdata (cfg_wdata),
		.cfg       (cfg),
		.lvl_wr    (lvl_wr)
	);

	bhre_core u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg),
		.lvl_wr (lvl_wr),
		.commit (advance),
		.smp    (in_s1),
		.pair   (pair)
	);

	bhre_out u_out (
		.clk       (clk),
		.arst_n    (arst_n),
		.load      (advance),
		.pair      (pair),
		.take      (take),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_data  (out_data)
	);

endmodule

`default_nettype wire
